>>> src/bft_pkg.sv
// Shared constants, codes and types of the bandpass FIR tap generator.
package bft_pkg;

  localparam int PHASE_BITS_DEF = 24;
  localparam int MAX_TAPS       = 255;
  localparam int COEF_FRAC_BITS = 22;

  // Phase unit: 47-bit numerator (cutoff times distance), 39-bit modulus.
  localparam int PH_NUM_W  = 47;
  localparam int PH_DEN_W  = 39;
  localparam int MOD_STEPS = 7;

  // Quotient divider for the sinc and centre values.
  localparam int DIV_NUM_W = 62;
  localparam int DIV_DEN_W = 40;
  localparam int QUO_BITS  = 31;

  localparam int CFG_ADDR_W = 5;

  localparam int SIN_TERMS = 5;
  localparam int SIN_LAT   = 4 + 3 * SIN_TERMS;

  localparam logic [30:0] ONE_Q30   = 31'd1073741824;
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [29:0] W54_Q30   = 30'd579820585;
  localparam logic [28:0] W46_Q30   = 29'd493921239;
  localparam logic [30:0] W_SUM_Q30 = 31'(W54_Q30) + 31'(W46_Q30);

  localparam logic [63:0] RECIP_ONE = 64'd1 << 33;

  // Taylor divisors, innermost term first, and floor(2^33 / divisor).
  localparam logic [6:0] SIN_DIV [SIN_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [30:0] SIN_RECIP [SIN_TERMS] = '{
    31'(RECIP_ONE / 64'd110), 31'(RECIP_ONE / 64'd72), 31'(RECIP_ONE / 64'd42),
    31'(RECIP_ONE / 64'd20), 31'(RECIP_ONE / 64'd6)};

  typedef enum logic [1:0] {
    REG_RATE = 2'd0,
    REG_TAPS = 2'd1,
    REG_LOW  = 2'd2,
    REG_HIGH = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RATE    = 3'd1,
    ST_ORDER   = 3'd2,
    ST_CUTOFF  = 3'd3,
    ST_NYQUIST = 3'd4,
    ST_INDEX   = 3'd5
  } status_t;

  typedef struct packed {
    logic        neg;
    logic [30:0] x;
    logic [31:0] x2;
  } sin_car_t;

  typedef struct packed {
    status_t     status;
    logic        center;
    logic        one_tap;
    logic [7:0]  ak;
  } side_t;

  typedef struct packed {
    status_t     status;
    logic        neg;
    logic [30:0] w;
  } tail_t;

endpackage

>>> src/bandpass_fir_tap_generator.sv
// Top level: config registers, checks and the coefficient pipeline.
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  ---------------------------
//  input     in_tap_index                           start high, busy low
//  result    out_coefficient, out_status            out_valid, one cycle
//  config    paddr, pwdata, prdata (64-bit regs)     psel/penable/pwrite, 8*i
//
// One item enters every cycle; busy never rises. Each item passes through
// the bit-per-stage phase fractions and the 31-stage quotient divider.
// Reset clears the valid bits and the config registers; items in flight drop.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module bandpass_fir_tap_generator import bft_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [7:0]            in_tap_index,
  output logic                  out_valid,
  output logic signed [23:0]    out_coefficient,
  output logic [2:0]            out_status
);

  localparam int L_PH       = 1 + MOD_STEPS + PHASE_BITS;
  localparam int D          = L_PH + SIN_LAT;
  localparam int PIPE_DEPTH = D + 4 + QUO_BITS;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

  // ---------------------------------------------------------------- config
  logic [30:0] sr_r;
  logic [7:0]  taps_r;
  logic [38:0] low_r;
  logic [38:0] high_r;
  reg_idx_t    ridx;

  assign ridx   = reg_idx_t'(paddr[4:3]);
  assign pready = 1'b1;
  assign busy   = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r   <= '0;
      taps_r <= '0;
      low_r  <= '0;
      high_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_RATE: sr_r   <= pwdata[30:0];
        REG_TAPS: taps_r <= pwdata[7:0];
        REG_LOW:  low_r  <= pwdata[38:0];
        REG_HIGH: high_r <= pwdata[38:0];
        default:  sr_r   <= sr_r;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_RATE: prdata = 64'(sr_r);
      REG_TAPS: prdata = 64'(taps_r);
      REG_LOW:  prdata = 64'(low_r);
      REG_HIGH: prdata = 64'(high_r);
      default:  prdata = '0;
    endcase
  end

  // -------------------------------------------- stage A: checks and distance
  status_t     st_nxt;
  logic [6:0]  mid;
  logic [7:0]  ak_nxt;
  side_t       a_r;
  logic [7:0]  a_idx_r;
  logic        a_vld_r;

  // First failing check wins.
  always_comb begin
    if (sr_r == '0) begin
      st_nxt = ST_RATE;
    end else if (taps_r == '0 || !taps_r[0] || {1'b0, taps_r} > 9'(MAX_TAPS)) begin
      st_nxt = ST_ORDER;
    end else if (high_r <= low_r) begin
      st_nxt = ST_CUTOFF;
    end else if (high_r >= 39'({sr_r, 7'b0})) begin
      st_nxt = ST_NYQUIST;
    end else if (in_tap_index >= taps_r) begin
      st_nxt = ST_INDEX;
    end else begin
      st_nxt = ST_OK;
    end
  end

  assign mid    = 7'((taps_r - 8'd1) >> 1);
  assign ak_nxt = (in_tap_index >= {1'b0, mid}) ? in_tap_index - {1'b0, mid}
                                                 : {1'b0, mid} - in_tap_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_r.status  <= st_nxt;
    a_r.center  <= (ak_nxt == '0);
    a_r.one_tap <= (taps_r == 8'd1);
    a_r.ak      <= ak_nxt;
    a_idx_r     <= in_tap_index;
  end

  // ------------------------------------------------ phases and the three sines
  logic [PH_NUM_W-1:0]   num_h;
  logic [PH_NUM_W-1:0]   num_l;
  logic [PH_NUM_W-1:0]   num_w;
  logic [PH_DEN_W-1:0]   den_c;
  logic [PH_DEN_W-1:0]   den_w;
  logic [PHASE_BITS-1:0] ph_h;
  logic [PHASE_BITS-1:0] ph_l;
  logic [PHASE_BITS-1:0] ph_w;
  logic [PHASE_BITS-1:0] ph_c;
  logic signed [31:0]    s_h;
  logic signed [31:0]    s_l;
  logic signed [31:0]    c_w;

  assign num_h = PH_NUM_W'(high_r) * PH_NUM_W'(a_r.ak);
  assign num_l = PH_NUM_W'(low_r) * PH_NUM_W'(a_r.ak);
  assign den_c = {sr_r, 8'b0};
  assign num_w = PH_NUM_W'(a_idx_r);
  assign den_w = PH_DEN_W'(taps_r - 8'd1);

  bft_phase #(.PHASE_BITS(PHASE_BITS)) u_ph_high (
    .clk(clk), .num_i(num_h), .den_i(den_c), .ph_o(ph_h));
  bft_phase #(.PHASE_BITS(PHASE_BITS)) u_ph_low (
    .clk(clk), .num_i(num_l), .den_i(den_c), .ph_o(ph_l));
  bft_phase #(.PHASE_BITS(PHASE_BITS)) u_ph_win (
    .clk(clk), .num_i(num_w), .den_i(den_w), .ph_o(ph_w));

  // Cosine is the sine a quarter turn ahead.
  assign ph_c = ph_w + QUARTER;

  bft_sine #(.PHASE_BITS(PHASE_BITS)) u_sin_high (.clk(clk), .ph_i(ph_h), .s_o(s_h));
  bft_sine #(.PHASE_BITS(PHASE_BITS)) u_sin_low  (.clk(clk), .ph_i(ph_l), .s_o(s_l));
  bft_sine #(.PHASE_BITS(PHASE_BITS)) u_cos_win  (.clk(clk), .ph_i(ph_c), .s_o(c_w));

  // Carry the item's side information alongside the phase and sine stages.
  side_t        sd_r [D];
  logic [D-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[D-2:0], a_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= a_r;
    for (int i = 1; i < D; i++) begin
      sd_r[i] <= sd_r[i-1];
    end
  end

  // ------------------------------------ C0: sine difference, divisor, window
  logic [32:0] dif33;
  logic [32:0] dabs;
  logic        c0_vld_r;
  side_t       c0_side_r;
  logic        c0_neg_r;
  logic [31:0] c0_dm_r;
  logic [39:0] c0_pdiv_r;
  logic [31:0] c0_cs_r;

  assign dif33 = {s_h[31], s_h} - {s_l[31], s_l};
  assign dabs  = dif33[32] ? 33'(-dif33) : dif33;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_vld_r <= 1'b0;
    end else begin
      c0_vld_r <= vld_r[D-1];
    end
  end

  always_ff @(posedge clk) begin
    c0_side_r <= sd_r[D-1];
    c0_neg_r  <= dif33[32];
    c0_dm_r   <= 32'(dabs);
    c0_pdiv_r <= 40'(PI_Q30) * 40'(sd_r[D-1].ak);
    c0_cs_r   <= 32'(c_w + $signed(32'(ONE_Q30)));
  end

  // ----------------------------------- C1: pick the division, finish window
  logic [60:0]          wprod;
  logic [30:0]          wv;
  logic                 c1_vld_r;
  logic [DIV_NUM_W-1:0] c1_num_r;
  logic [DIV_DEN_W-1:0] c1_den_r;
  tail_t                c1_tail_r;

  assign wprod = 61'(W46_Q30) * 61'(c0_cs_r);
  assign wv    = W_SUM_Q30 - 31'(wprod >> 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= c0_vld_r;
    end
  end

  // Centre tap takes 2*(f2-f1); a single tap takes a unit window.
  always_ff @(posedge clk) begin
    c1_num_r <= c0_side_r.center ? (DIV_NUM_W'(high_r - low_r) << 23)
                                 : (DIV_NUM_W'(c0_dm_r) << 30);
    c1_den_r <= c0_side_r.center ? DIV_DEN_W'(sr_r) : c0_pdiv_r;
    c1_tail_r.status <= c0_side_r.status;
    c1_tail_r.neg    <= c0_side_r.center ? 1'b0 : c0_neg_r;
    c1_tail_r.w      <= c0_side_r.one_tap ? ONE_Q30 : wv;
  end

  // -------------------------------------------------------------- divider
  logic [QUO_BITS-1:0] quo;
  tail_t               td_r [QUO_BITS];
  logic [QUO_BITS-1:0] vld2_r;

  bft_div u_div (.clk(clk), .num_i(c1_num_r), .den_i(c1_den_r), .quo_o(quo));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= '0;
    end else begin
      vld2_r <= {vld2_r[QUO_BITS-2:0], c1_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    td_r[0] <= c1_tail_r;
    for (int i = 1; i < QUO_BITS; i++) begin
      td_r[i] <= td_r[i-1];
    end
  end

  // ------------------------------------------ M0: apply window, M1: round
  logic        m0_vld_r;
  logic [61:0] m0_prod_r;
  tail_t       m0_tail_r;
  logic [62:0] rsum;
  logic [62:0] mag;
  logic [23:0] coef_nxt;
  logic        out_valid_r;
  logic [23:0] out_coef_r;
  status_t     out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_vld_r <= 1'b0;
    end else begin
      m0_vld_r <= vld2_r[QUO_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    m0_prod_r <= 62'(quo) * 62'(td_r[QUO_BITS-1].w);
    m0_tail_r <= td_r[QUO_BITS-1];
  end

  // Round half away from zero on the magnitude, then saturate.
  assign rsum = 63'(m0_prod_r) + (63'(1) << (59 - COEF_FRAC_BITS));
  assign mag  = rsum >> (60 - COEF_FRAC_BITS);

  always_comb begin
    if (m0_tail_r.status != ST_OK) begin
      coef_nxt = '0;
    end else if (m0_tail_r.neg) begin
      coef_nxt = (mag > 63'd8388608) ? 24'h800000 : 24'(-mag);
    end else begin
      coef_nxt = (mag > 63'd8388607) ? 24'h7fffff : 24'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_coef_r   <= coef_nxt;
    out_status_r <= m0_tail_r.status;
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = $signed(out_coef_r);
  assign out_status      = out_status_r;

  // ------------------------------------------------------------ assertions
  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##PIPE_DEPTH out_valid)
    else $error("accepted item produced no result");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH + 1))
    else $error("result without an accepted item");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_coefficient == '0)
    else $error("failed check with nonzero coefficient");

  a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
    m0_vld_r && m0_tail_r.neg && m0_tail_r.status == ST_OK
      |=> out_coefficient[23] || out_coefficient == '0)
    else $error("negative coefficient lost its sign");

endmodule

>>> src/bft_phase.sv
// Phase unit: pipelined modulo reduction followed by a bit-per-stage fraction.
module bft_phase import bft_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic [PH_NUM_W-1:0]   num_i,
  input  logic [PH_DEN_W-1:0]   den_i,
  output logic [PHASE_BITS-1:0] ph_o
);

  localparam int CMP_W = PH_NUM_W + MOD_STEPS;

  logic [PH_NUM_W-1:0]   rem_r  [MOD_STEPS+1];
  logic [PH_DEN_W-1:0]   mden_r [MOD_STEPS+1];
  logic [PH_DEN_W-1:0]   fr_r   [PHASE_BITS];
  logic [PH_DEN_W-1:0]   fden_r [PHASE_BITS-1];
  logic [PHASE_BITS-1:0] q_r    [PHASE_BITS];

  always_ff @(posedge clk) begin
    rem_r[0]  <= num_i;
    mden_r[0] <= den_i;
  end

  // Subtract the shifted modulus, largest multiple first.
  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    logic [CMP_W-1:0] cand;
    logic [CMP_W-1:0] dif;
    assign cand = CMP_W'(mden_r[j]) << (MOD_STEPS - 1 - j);
    assign dif  = CMP_W'(rem_r[j]) - cand;
    always_ff @(posedge clk) begin
      rem_r[j+1]  <= (CMP_W'(rem_r[j]) >= cand) ? PH_NUM_W'(dif) : rem_r[j];
      mden_r[j+1] <= mden_r[j];
    end
  end

  // One fraction bit per stage.
  for (genvar b = 0; b < PHASE_BITS; b++) begin : g_frac
    logic [PH_DEN_W-1:0]   r_in;
    logic [PH_DEN_W-1:0]   d_in;
    logic [PHASE_BITS-1:0] q_in;
    logic [PH_DEN_W:0]     dbl;
    logic [PH_DEN_W:0]     dif;
    if (b == 0) begin : g_first
      assign r_in = PH_DEN_W'(rem_r[MOD_STEPS]);
      assign d_in = mden_r[MOD_STEPS];
      assign q_in = '0;
    end else begin : g_next
      assign r_in = fr_r[b-1];
      assign d_in = fden_r[b-1];
      assign q_in = q_r[b-1];
    end
    assign dbl = {r_in, 1'b0};
    assign dif = dbl - {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (dbl >= {1'b0, d_in}) begin
        fr_r[b] <= PH_DEN_W'(dif);
        q_r[b]  <= {q_in[PHASE_BITS-2:0], 1'b1};
      end else begin
        fr_r[b] <= PH_DEN_W'(dbl);
        q_r[b]  <= {q_in[PHASE_BITS-2:0], 1'b0};
      end
    end
    if (b < PHASE_BITS - 1) begin : g_den
      always_ff @(posedge clk) begin
        fden_r[b] <= d_in;
      end
    end
  end

  assign ph_o = q_r[PHASE_BITS-1];

endmodule

>>> src/bft_sine.sv
// Pipelined sine of a phase: quarter-wave fold and Horner Taylor series in Q30.
module bft_sine import bft_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic [PHASE_BITS-1:0] ph_i,
  output logic signed [31:0]    s_o
);

  localparam int QW = PHASE_BITS - 2;

  logic [1:0]    quad;
  logic [QW:0]   rf;
  logic [QW:0]   rf_r;
  logic          nf_r;
  logic [30:0]   x_r;
  logic          nx_r;
  sin_car_t      car_r;
  logic [31:0]   p_r   [SIN_TERMS];
  logic [31:0]   pb_r  [SIN_TERMS];
  logic [29:0]   q0_r  [SIN_TERMS];
  logic [30:0]   t_r   [SIN_TERMS];
  sin_car_t      car1_r [SIN_TERMS];
  sin_car_t      car2_r [SIN_TERMS];
  sin_car_t      car3_r [SIN_TERMS];
  sin_car_t      carin [SIN_TERMS+1];
  logic [30:0]   tin   [SIN_TERMS+1];
  logic [30:0]   sv;
  logic [31:0]   s32;
  logic [31:0]   s_r;

  assign quad = ph_i[PHASE_BITS-1:PHASE_BITS-2];
  assign rf   = quad[0] ? ({1'b1, {QW{1'b0}}} - {1'b0, ph_i[QW-1:0]})
                        : {1'b0, ph_i[QW-1:0]};

  always_ff @(posedge clk) begin
    rf_r     <= rf;
    nf_r     <= quad[1];
    x_r      <= 31'((64'(rf_r) * 64'(PI_Q30)) >> (PHASE_BITS - 1));
    nx_r     <= nf_r;
    car_r.x2 <= 32'((64'(x_r) * 64'(x_r)) >> 30);
    car_r.x  <= x_r;
    car_r.neg <= nx_r;
  end

  assign carin[0] = car_r;
  assign tin[0]   = ONE_Q30;

  // Each term: multiply, divide by reciprocal, correct and subtract from one.
  for (genvar n = 0; n < SIN_TERMS; n++) begin : g_term
    logic [32:0] rem;
    logic [29:0] qc;
    assign rem = 33'(pb_r[n]) - 33'(q0_r[n]) * 33'(SIN_DIV[n]);
    assign qc  = q0_r[n] + 30'(rem >= 33'(SIN_DIV[n]));
    always_ff @(posedge clk) begin
      p_r[n]    <= 32'((64'(carin[n].x2) * 64'(tin[n])) >> 30);
      car1_r[n] <= carin[n];
      q0_r[n]   <= 30'((64'(p_r[n]) * 64'(SIN_RECIP[n])) >> 33);
      pb_r[n]   <= p_r[n];
      car2_r[n] <= car1_r[n];
      t_r[n]    <= ONE_Q30 - 31'(qc);
      car3_r[n] <= car2_r[n];
    end
    assign carin[n+1] = car3_r[n];
    assign tin[n+1]   = t_r[n];
  end

  assign sv  = 31'((64'(carin[SIN_TERMS].x) * 64'(tin[SIN_TERMS])) >> 30);
  assign s32 = {1'b0, sv};

  always_ff @(posedge clk) begin
    s_r <= carin[SIN_TERMS].neg ? 32'(-s32) : s32;
  end

  assign s_o = s_r;

endmodule

>>> src/bft_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module bft_div import bft_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [QUO_BITS-1:0]  quo_o
);

  localparam int CW = DIV_DEN_W + QUO_BITS;

  logic [DIV_NUM_W-1:0] rem_r [QUO_BITS-1];
  logic [DIV_DEN_W-1:0] den_r [QUO_BITS-1];
  logic [QUO_BITS-1:0]  q_r   [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    logic [DIV_NUM_W-1:0] r_in;
    logic [DIV_DEN_W-1:0] d_in;
    logic [QUO_BITS-1:0]  q_in;
    logic [CW-1:0]        cand;
    logic                 ge;
    if (k == 0) begin : g_first
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
      assign q_in = q_r[k-1];
    end
    assign cand = CW'(d_in) << (QUO_BITS - 1 - k);
    assign ge   = CW'(r_in) >= cand;
    always_ff @(posedge clk) begin
      q_r[k] <= {q_in[QUO_BITS-2:0], ge};
    end
    if (k < QUO_BITS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? DIV_NUM_W'(CW'(r_in) - cand) : r_in;
        den_r[k] <= d_in;
      end
    end
  end

  assign quo_o = q_r[QUO_BITS-1];

endmodule
